/* design/sdas_pkg.sv */
// Shared types, codes and constants for the SWD debug access sequencer.
// No dependencies; the top, front and back files import this package.
package sdas_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [3:0] OP_READ_DP    = 4'd0;
    localparam logic [3:0] OP_WRITE_DP   = 4'd1;
    localparam logic [3:0] OP_READ_AP    = 4'd2;
    localparam logic [3:0] OP_WRITE_AP   = 4'd3;
    localparam logic [3:0] OP_MEM_READ   = 4'd4;
    localparam logic [3:0] OP_MEM_WRITE  = 4'd5;
    localparam logic [3:0] OP_CONNECT    = 4'd6;
    localparam logic [3:0] OP_DISCONNECT = 4'd7;
    localparam logic [3:0] OP_PHY_REPLY  = 4'd8;

    localparam logic [1:0] ACK_OK    = 2'd0;
    localparam logic [1:0] ACK_WAIT  = 2'd1;
    localparam logic [1:0] ACK_FAULT = 2'd2;
    localparam logic [1:0] ACK_LINK  = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FAULT   = 3'd1;
    localparam logic [2:0] ST_TIMEOUT = 3'd2;
    localparam logic [2:0] ST_LINK    = 3'd3;
    localparam logic [2:0] ST_BAD_ID  = 3'd4;
    localparam logic [2:0] ST_BAD_ARG = 3'd5;

    localparam logic [2:0] STG_NONE  = 3'd0;
    localparam logic [2:0] STG_DPIDR = 3'd1;
    localparam logic [2:0] STG_ABORT = 3'd2;
    localparam logic [2:0] STG_SEL   = 3'd3;
    localparam logic [2:0] STG_PREQ  = 3'd4;
    localparam logic [2:0] STG_PACK  = 3'd5;
    localparam logic [2:0] STG_APIDR = 3'd6;
    localparam logic [2:0] STG_CSW   = 3'd7;

    localparam logic [1:0] CFG_WAIT_LIMIT = 2'd0;
    localparam logic [1:0] CFG_POLL_LIMIT = 2'd1;
    localparam logic [1:0] CFG_CSW        = 2'd2;

    localparam logic [1:0] REG_ABORT  = 2'd0;
    localparam logic [1:0] REG_CTRL   = 2'd1;
    localparam logic [1:0] REG_SELECT = 2'd2;
    localparam logic [1:0] REG_RDBUFF = 2'd3;

    localparam logic [7:0]  LIMIT_RESET  = 8'd100;
    localparam logic [31:0] CSW_RESET    = 32'h2300_0052;
    localparam logic [31:0] ABORT_CLEAR  = 32'h0000_001E;
    localparam logic [31:0] PWR_REQ      = 32'h5000_0000;
    localparam logic [31:0] PWR_ACK      = 32'hA000_0000;
    localparam logic [31:0] APSEL_MASK   = 32'h0000_00F0;
    localparam logic [31:0] IDR_BANK_SEL = 32'h0000_00F0;
    localparam logic [3:0]  IDR_BANK     = 4'hF;

    typedef enum logic [4:0] {
        S_IDLE, S_DP, S_AP_SEL, S_AP, S_RDBUF, S_FABORT, S_M_SEL, S_M_CSW,
        S_M_TAR, S_M_DRW, S_M_RDBUF, S_C_ID, S_C_ABORT, S_C_SEL, S_C_PREQ,
        S_C_POLL, S_C_PABORT, S_C_ISEL, S_C_IAP, S_C_IRDBUF, S_C_CSEL, S_C_CSW
    } step_t;

    typedef struct packed {
        logic [3:0]  operation;
        logic [31:0] address;
        logic [31:0] write_data;
        logic [1:0]  phy_ack;
        logic [31:0] phy_read_data;
    } item_t;

    typedef struct packed {
        logic        kind;
        logic        req_ap;
        logic        req_read;
        logic [1:0]  req_reg;
        logic [31:0] req_data;
        logic [2:0]  status;
        logic [31:0] read_value;
        logic [31:0] ap_id;
        logic [2:0]  fail_stage;
    } result_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

    function automatic logic [2:0] stage_of(step_t s);
        logic [2:0] r;
        r = STG_NONE;
        unique case (s)
            S_C_ID:                           r = STG_DPIDR;
            S_C_ABORT:                        r = STG_ABORT;
            S_C_SEL:                          r = STG_SEL;
            S_C_PREQ:                         r = STG_PREQ;
            S_C_POLL, S_C_PABORT:             r = STG_PACK;
            S_C_ISEL, S_C_IAP, S_C_IRDBUF:    r = STG_APIDR;
            S_C_CSEL, S_C_CSW:                r = STG_CSW;
            default:                          r = STG_NONE;
        endcase
        return r;
    endfunction

endpackage

/* design/sdas_if.sv */
// Handshake channel interfaces for command/reply beats and result beats.
// Depends on nothing.
interface sdas_cmd_if;
    logic        valid;
    logic        ready;
    logic [3:0]  operation;
    logic [31:0] address;
    logic [31:0] write_data;
    logic [1:0]  phy_ack;
    logic [31:0] phy_read_data;

    modport source (output valid, operation, address, write_data, phy_ack, phy_read_data,
                    input ready);
    modport sink   (input valid, operation, address, write_data, phy_ack, phy_read_data,
                    output ready);
endinterface

interface sdas_res_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic        req_ap;
    logic        req_read;
    logic [1:0]  req_reg;
    logic [31:0] req_data;
    logic [2:0]  status;
    logic [31:0] read_value;
    logic [31:0] ap_id;
    logic [2:0]  fail_stage;

    modport source (output valid, kind, req_ap, req_read, req_reg, req_data, status,
                    read_value, ap_id, fail_stage, input ready);
    modport sink   (input valid, kind, req_ap, req_read, req_reg, req_data, status,
                    read_value, ap_id, fail_stage, output ready);
endinterface

/* design/swd_debug_access_sequencer_core.sv */
// Top level of the SWD debug access sequencer: front queue plus sequencer.
// Depends on sdas_pkg, sdas_if, sdas_front and sdas_back.
//
//  channel | dir | beat contents
//  cmd     | in  | host command or phy reply (operation, address, data, ack)
//  res     | out | SWD transfer request or host completion
//  cfg     | in  | register write (cfg_we, cfg_index, cfg_data)
//
// One beat per cycle is taken while the 4-entry queue has room; the sequencer
// retires one queued beat per cycle, held only while a result is stalled in the
// result register. A beat is registered in a queue entry and then in the result
// register. Reset clears all but the queue and result data; no clearing pass.
module swd_debug_access_sequencer_core (
    input  logic        clk,
    input  logic        rst_n,
    sdas_cmd_if.sink    cmd,
    sdas_res_if.source  res,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import sdas_pkg::*;

    item_t       in_item;
    queue_head_t head;
    logic        pop;
    result_t     out_res;

    assign in_item.operation     = cmd.operation;
    assign in_item.address       = cmd.address;
    assign in_item.write_data    = cmd.write_data;
    assign in_item.phy_ack       = cmd.phy_ack;
    assign in_item.phy_read_data = cmd.phy_read_data;

    sdas_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_ready (cmd.ready),
        .in_item  (in_item),
        .head     (head),
        .pop      (pop)
    );

    sdas_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .head      (head),
        .pop       (pop),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .out_res   (out_res)
    );

    assign res.kind       = out_res.kind;
    assign res.req_ap     = out_res.req_ap;
    assign res.req_read   = out_res.req_read;
    assign res.req_reg    = out_res.req_reg;
    assign res.req_data   = out_res.req_data;
    assign res.status     = out_res.status;
    assign res.read_value = out_res.read_value;
    assign res.ap_id      = out_res.ap_id;
    assign res.fail_stage = out_res.fail_stage;

endmodule

/* design/sdas_front.sv */
// Front end: takes command/reply beats, drops undefined operations and
// queues the rest for the sequencer. Depends on sdas_pkg.
module sdas_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sdas_pkg::item_t     in_item,
    output sdas_pkg::queue_head_t head,
    input  logic                pop
);
    import sdas_pkg::*;

    item_t                q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]      count_reg, count_next;
    logic                 push;

    assign in_ready = (count_reg != QUEUE_DEPTH[QPTR_W:0]);
    // undefined operations never reach the queue
    assign push = in_valid && in_ready && (in_item.operation <= OP_PHY_REPLY);

    assign head.valid = (count_reg != '0);
    assign head.item  = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= in_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* design/sdas_back.sv */
// Back end: the transfer sequencer, its bank cache, config registers and the
// result register. Depends on sdas_pkg.
module sdas_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [31:0]           cfg_data,
    input  sdas_pkg::queue_head_t head,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output sdas_pkg::result_t     out_res
);
    import sdas_pkg::*;

    logic [7:0]  wait_limit_reg, poll_limit_reg;
    logic [31:0] csw_reg;

    step_t       step_reg, step_next;
    logic [3:0]  cmd_reg, cmd_next;
    logic        bank_valid_reg, bank_valid_next;
    logic [3:0]  bank_reg, bank_next;
    logic        connected_reg, connected_next;
    logic [7:0]  retry_reg, retry_next;
    logic [7:0]  poll_reg, poll_next;
    logic [31:0] addr_reg, addr_next;
    logic [31:0] data_reg, data_next;
    logic [31:0] dpid_reg, dpid_next;
    logic [2:0]  pend_reg, pend_next;
    logic [2:0]  astage_reg, astage_next;

    logic        out_valid_reg;
    result_t     out_res_reg;

    logic        do_go, do_emit, do_fin, do_pfail;
    step_t       go_step;
    logic [2:0]  fin_st, fin_stage;
    logic [31:0] fin_val;
    logic [7:0]  retry_inc, poll_inc;
    logic [3:0]  ap_bank;
    item_t       it;
    result_t     res;

    assign it        = head.item;
    assign pop       = head.valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
    assign ap_bank   = addr_reg[7:4];
    assign retry_inc = retry_reg + 8'd1;
    assign poll_inc  = poll_reg + 8'd1;

    always_comb
    begin
        step_next = step_reg;  cmd_next = cmd_reg;  bank_valid_next = bank_valid_reg;
        bank_next = bank_reg;  connected_next = connected_reg;  retry_next = retry_reg;
        poll_next = poll_reg;  addr_next = addr_reg;  data_next = data_reg;
        dpid_next = dpid_reg;  pend_next = pend_reg;  astage_next = astage_reg;
        do_go = 1'b0;  go_step = S_IDLE;  do_emit = 1'b0;  do_fin = 1'b0;
        do_pfail = 1'b0;  fin_st = ST_OK;  fin_val = '0;  fin_stage = STG_NONE;

        if (pop && it.operation == OP_PHY_REPLY && step_reg != S_IDLE)
        begin
            if (step_reg == S_FABORT)
            begin
                do_fin = 1'b1;  fin_st = pend_reg;  fin_stage = astage_reg;
            end
            else if (step_reg == S_C_PABORT)
                do_pfail = 1'b1;
            else if (it.phy_ack == ACK_OK)
            begin
                unique case (step_reg)
                    S_DP:
                    begin
                        if (cmd_reg == OP_WRITE_DP && addr_reg[3:2] == REG_SELECT)
                            bank_valid_next = 1'b0;
                        do_fin = 1'b1;
                        fin_val = (cmd_reg == OP_READ_DP) ? it.phy_read_data : '0;
                    end
                    S_AP_SEL:
                    begin
                        bank_valid_next = 1'b1;  bank_next = ap_bank;
                        do_go = 1'b1;  go_step = S_AP;
                    end
                    S_AP:
                        if (cmd_reg == OP_READ_AP)
                        begin
                            do_go = 1'b1;  go_step = S_RDBUF;
                        end
                        else
                            do_fin = 1'b1;
                    S_RDBUF, S_M_RDBUF:
                    begin
                        do_fin = 1'b1;  fin_val = it.phy_read_data;
                    end
                    S_M_SEL:
                    begin
                        bank_valid_next = 1'b1;  bank_next = '0;
                        do_go = 1'b1;  go_step = S_M_CSW;
                    end
                    S_M_CSW:
                    begin
                        do_go = 1'b1;  go_step = S_M_TAR;
                    end
                    S_M_TAR:
                    begin
                        do_go = 1'b1;  go_step = S_M_DRW;
                    end
                    S_M_DRW:
                        if (cmd_reg == OP_MEM_READ)
                        begin
                            do_go = 1'b1;  go_step = S_M_RDBUF;
                        end
                        else
                            do_fin = 1'b1;
                    S_C_ID:
                    begin
                        dpid_next = it.phy_read_data;
                        if (it.phy_read_data == '0 || it.phy_read_data == '1)
                        begin
                            do_fin = 1'b1;  fin_st = ST_BAD_ID;  fin_stage = STG_DPIDR;
                        end
                        else
                        begin
                            do_go = 1'b1;  go_step = S_C_ABORT;
                        end
                    end
                    S_C_ABORT:
                    begin
                        do_go = 1'b1;  go_step = S_C_SEL;
                    end
                    S_C_SEL:
                    begin
                        bank_valid_next = 1'b1;  bank_next = '0;
                        do_go = 1'b1;  go_step = S_C_PREQ;
                    end
                    S_C_PREQ:
                    begin
                        poll_next = '0;
                        do_go = 1'b1;  go_step = S_C_POLL;
                    end
                    S_C_POLL:
                        if ((it.phy_read_data & PWR_ACK) != PWR_ACK)
                            do_pfail = 1'b1;
                        else
                        begin
                            do_go = 1'b1;
                            go_step = (bank_valid_reg && bank_reg == IDR_BANK)
                                      ? S_C_IAP : S_C_ISEL;
                        end
                    S_C_ISEL:
                    begin
                        bank_valid_next = 1'b1;  bank_next = IDR_BANK;
                        do_go = 1'b1;  go_step = S_C_IAP;
                    end
                    S_C_IAP:
                    begin
                        do_go = 1'b1;  go_step = S_C_IRDBUF;
                    end
                    S_C_IRDBUF:
                    begin
                        data_next = it.phy_read_data;
                        if (it.phy_read_data == '0 || it.phy_read_data == '1)
                        begin
                            do_fin = 1'b1;  fin_st = ST_BAD_ID;  fin_stage = STG_APIDR;
                        end
                        else
                        begin
                            do_go = 1'b1;
                            go_step = (bank_valid_reg && bank_reg == 4'd0)
                                      ? S_C_CSW : S_C_CSEL;
                        end
                    end
                    S_C_CSEL:
                    begin
                        bank_valid_next = 1'b1;  bank_next = '0;
                        do_go = 1'b1;  go_step = S_C_CSW;
                    end
                    S_C_CSW:
                    begin
                        connected_next = 1'b1;
                        do_fin = 1'b1;
                    end
                    default:
                        step_next = S_IDLE;
                endcase
            end
            else if (it.phy_ack == ACK_FAULT)
            begin
                if (step_reg == S_C_POLL)
                begin
                    do_go = 1'b1;  go_step = S_C_PABORT;
                end
                else
                begin
                    astage_next = stage_of(step_reg);
                    pend_next = ST_FAULT;
                    do_go = 1'b1;  go_step = S_FABORT;
                end
            end
            else
            begin
                fin_st = ST_LINK;
                if (it.phy_ack == ACK_WAIT)
                    fin_st = ST_TIMEOUT;
                if (it.phy_ack == ACK_WAIT && retry_inc < wait_limit_reg)
                begin
                    retry_next = retry_inc;
                    do_emit = 1'b1;
                end
                else if (step_reg == S_C_POLL)
                    do_pfail = 1'b1;
                else
                begin
                    retry_next = retry_inc;
                    do_fin = 1'b1;  fin_stage = stage_of(step_reg);
                end
            end
        end
        else if (pop && it.operation != OP_PHY_REPLY && step_reg == S_IDLE)
        begin
            cmd_next = it.operation;
            case (it.operation)
                OP_READ_DP, OP_WRITE_DP:
                begin
                    addr_next = {24'd0, it.address[7:0]};  data_next = it.write_data;
                    do_go = 1'b1;  go_step = S_DP;
                end
                OP_READ_AP, OP_WRITE_AP:
                begin
                    addr_next = {24'd0, it.address[7:0]};  data_next = it.write_data;
                    do_go = 1'b1;
                    go_step = (bank_valid_reg && bank_reg == it.address[7:4])
                              ? S_AP : S_AP_SEL;
                end
                OP_MEM_READ, OP_MEM_WRITE:
                    if (!connected_reg || it.address[1:0] != 2'd0)
                    begin
                        do_fin = 1'b1;  fin_st = ST_BAD_ARG;
                    end
                    else
                    begin
                        addr_next = it.address;  data_next = it.write_data;
                        do_go = 1'b1;
                        go_step = (bank_valid_reg && bank_reg == 4'd0) ? S_M_CSW : S_M_SEL;
                    end
                OP_CONNECT:
                begin
                    connected_next = 1'b0;  bank_valid_next = 1'b0;
                    dpid_next = '0;  data_next = '0;
                    do_go = 1'b1;  go_step = S_C_ID;
                end
                default:
                begin
                    connected_next = 1'b0;
                    do_fin = 1'b1;
                end
            endcase
        end

        // a failed power poll either retries the poll or ends the connect
        if (do_pfail)
        begin
            poll_next = poll_inc;
            if (poll_inc >= poll_limit_reg)
            begin
                do_fin = 1'b1;  fin_st = ST_TIMEOUT;  fin_val = '0;  fin_stage = STG_PACK;
            end
            else
            begin
                do_go = 1'b1;  go_step = S_C_POLL;
            end
        end
        if (do_go)
        begin
            step_next = go_step;  retry_next = '0;  do_emit = 1'b1;
        end
        if (do_fin)
        begin
            step_next = S_IDLE;  pend_next = fin_st;
        end
    end

    // result word: request built from the step just entered, or a completion
    always_comb
    begin
        res = '0;
        if (do_fin)
        begin
            res.kind   = 1'b1;
            res.status = fin_st;
            if (cmd_next == OP_CONNECT)
            begin
                res.read_value = dpid_next;
                res.ap_id      = data_next;
                res.fail_stage = fin_stage;
            end
            else
                res.read_value = fin_val;
        end
        else
        begin
            case (step_next)
                S_DP:
                begin
                    res.req_read = (cmd_next == OP_READ_DP);
                    res.req_reg  = addr_next[3:2];
                    res.req_data = (cmd_next == OP_WRITE_DP) ? data_next : '0;
                end
                S_AP_SEL:
                begin
                    res.req_reg  = REG_SELECT;
                    res.req_data = addr_next & APSEL_MASK;
                end
                S_M_SEL, S_C_SEL, S_C_CSEL:
                    res.req_reg = REG_SELECT;
                S_C_ISEL:
                begin
                    res.req_reg  = REG_SELECT;
                    res.req_data = IDR_BANK_SEL;
                end
                S_AP:
                begin
                    res.req_ap   = 1'b1;
                    res.req_read = (cmd_next == OP_READ_AP);
                    res.req_reg  = addr_next[3:2];
                    res.req_data = (cmd_next == OP_WRITE_AP) ? data_next : '0;
                end
                S_RDBUF, S_M_RDBUF, S_C_IRDBUF:
                begin
                    res.req_read = 1'b1;
                    res.req_reg  = REG_RDBUFF;
                end
                S_FABORT, S_C_ABORT, S_C_PABORT:
                begin
                    res.req_reg  = REG_ABORT;
                    res.req_data = ABORT_CLEAR;
                end
                S_M_CSW, S_C_CSW:
                begin
                    res.req_ap   = 1'b1;
                    res.req_data = csw_reg;
                end
                S_M_TAR:
                begin
                    res.req_ap   = 1'b1;
                    res.req_reg  = 2'd1;
                    res.req_data = addr_next;
                end
                S_M_DRW:
                begin
                    res.req_ap   = 1'b1;
                    res.req_read = (cmd_next == OP_MEM_READ);
                    res.req_reg  = 2'd3;
                    res.req_data = (cmd_next == OP_MEM_WRITE) ? data_next : '0;
                end
                S_C_ID:
                    res.req_read = 1'b1;
                S_C_PREQ:
                begin
                    res.req_reg  = REG_CTRL;
                    res.req_data = PWR_REQ;
                end
                S_C_POLL:
                begin
                    res.req_read = 1'b1;
                    res.req_reg  = REG_CTRL;
                end
                S_C_IAP:
                begin
                    res.req_ap   = 1'b1;
                    res.req_read = 1'b1;
                    res.req_reg  = 2'd3;
                end
                default:
                    res = '0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && (do_emit || do_fin))
            out_res_reg <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_limit_reg <= LIMIT_RESET;  poll_limit_reg <= LIMIT_RESET;
            csw_reg <= CSW_RESET;
            step_reg <= S_IDLE;  cmd_reg <= '0;  bank_valid_reg <= 1'b0;
            bank_reg <= '0;  connected_reg <= 1'b0;  retry_reg <= '0;
            poll_reg <= '0;  addr_reg <= '0;  data_reg <= '0;  dpid_reg <= '0;
            pend_reg <= '0;  astage_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_WAIT_LIMIT: wait_limit_reg <= cfg_data[7:0];
                    CFG_POLL_LIMIT: poll_limit_reg <= cfg_data[7:0];
                    CFG_CSW:        csw_reg <= cfg_data;
                    default:        ;
                endcase
            end
            step_reg <= step_next;  cmd_reg <= cmd_next;
            bank_valid_reg <= bank_valid_next;  bank_reg <= bank_next;
            connected_reg <= connected_next;  retry_reg <= retry_next;
            poll_reg <= poll_next;  addr_reg <= addr_next;  data_reg <= data_next;
            dpid_reg <= dpid_next;  pend_reg <= pend_next;  astage_reg <= astage_next;
            if (pop && (do_emit || do_fin))
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

/* design/sdas_checker.sv */
// Port-level checks on the sequencer's result channel, bound to the top.
// Depends on swd_debug_access_sequencer_core.
module sdas_assertions (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic        kind,
    input logic        req_ap,
    input logic        req_read,
    input logic [1:0]  req_reg,
    input logic [31:0] req_data,
    input logic [2:0]  status,
    input logic [31:0] read_value,
    input logic [31:0] ap_id,
    input logic [2:0]  fail_stage
);
    a_req_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !kind |-> status == 3'd0 && read_value == '0 && ap_id == '0
                               && fail_stage == 3'd0)
        else $error("request carries completion fields");

    a_cpl_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && kind |-> !req_ap && !req_read && req_reg == 2'd0 && req_data == '0)
        else $error("completion carries request fields");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && kind |-> status <= 3'd5)
        else $error("undefined status code");

    a_read_nodata: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !kind && req_read |-> req_data == '0)
        else $error("read request with data");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(req_data) && $stable(kind)
                                    && $stable(read_value))
        else $error("stalled result beat changed");

endmodule

bind swd_debug_access_sequencer_core sdas_assertions u_sdas_assertions (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .kind       (res.kind),
    .req_ap     (res.req_ap),
    .req_read   (res.req_read),
    .req_reg    (res.req_reg),
    .req_data   (res.req_data),
    .status     (res.status),
    .read_value (res.read_value),
    .ap_id      (res.ap_id),
    .fail_stage (res.fail_stage)
);
